>>> hw/rtl/lr_pkg.sv
`default_nettype none

package lr_pkg;

    // Default coordinate width and the fixed color width.
    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 24;

    // Depth of the queue between the command front end and the walker.
    localparam int QUEUE_DEPTH = 4;

    // Command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/lr_if.sv
`default_nettype none

// Command channel: one item is a start or a step command.
interface lr_in_if #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic [lr_pkg::COLOR_BITS-1:0] color;

    modport source (output valid, command, start_x, start_y, end_x, end_y, color,
                    input ready);
    modport sink (input valid, command, start_x, start_y, end_x, end_y, color,
                  output ready);
endinterface

// Pixel channel: one item is one answer to a command.
interface lr_out_if #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic [lr_pkg::COLOR_BITS-1:0] pixel_color;
    logic                          pixel_valid;
    logic                          last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid, last,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, pixel_valid, last,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lr_fifo.sv
`default_nettype none

module lr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update, pointers wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy exceeds depth");

endmodule

`default_nettype wire

>>> hw/rtl/lr_front.sv
`default_nettype none

module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 4 + 6 * COORD_BITS + lr_pkg::COLOR_BITS
) (
    lr_in_if.sink              i_cmd,
    input  wire logic          i_full,
    output logic               o_push,
    output logic [ENTRY_W-1:0] o_entry
);
    import lr_pkg::*;

    localparam int C = COORD_BITS;

    typedef struct packed {
        logic                   cmd;
        logic [C-1:0]           x0;
        logic [C-1:0]           y0;
        logic [C-1:0]           x1;
        logic [C-1:0]           y1;
        logic [C-1:0]           dx;
        logic [C-1:0]           dy;
        logic                   sx_neg;
        logic                   sy_neg;
        logic                   single;
        logic [COLOR_BITS-1:0]  color;
    } t_entry;

    logic signed [C:0] diff_x, diff_y;
    logic [C:0]        abs_x, abs_y;
    t_entry            entry;

    // Take an item whenever the queue has room.
    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;

    // Signed differences of the endpoints, one bit wider so they cannot wrap.
    assign diff_x = {i_cmd.end_x[C-1], i_cmd.end_x} - {i_cmd.start_x[C-1], i_cmd.start_x};
    assign diff_y = {i_cmd.end_y[C-1], i_cmd.end_y} - {i_cmd.start_y[C-1], i_cmd.start_y};
    assign abs_x  = diff_x[C] ? (C+1)'(-diff_x) : diff_x;
    assign abs_y  = diff_y[C] ? (C+1)'(-diff_y) : diff_y;

    // Classify the command and precompute the line setup.
    always_comb begin
        entry.cmd    = i_cmd.command;
        entry.x0     = i_cmd.start_x;
        entry.y0     = i_cmd.start_y;
        entry.x1     = i_cmd.end_x;
        entry.y1     = i_cmd.end_y;
        entry.dx     = abs_x[C-1:0];
        entry.dy     = abs_y[C-1:0];
        entry.sx_neg = !(i_cmd.start_x < i_cmd.end_x);
        entry.sy_neg = !(i_cmd.start_y < i_cmd.end_y);
        entry.single = (i_cmd.start_x == i_cmd.end_x) && (i_cmd.start_y == i_cmd.end_y);
        entry.color  = i_cmd.color;
    end

    assign o_entry = entry;

endmodule

`default_nettype wire

>>> hw/rtl/lr_back.sv
`default_nettype none

module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 4 + 6 * COORD_BITS + lr_pkg::COLOR_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_pop,
    lr_out_if.source                o_pix
);
    import lr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int EW = C + 3;

    typedef struct packed {
        logic                   cmd;
        logic [C-1:0]           x0;
        logic [C-1:0]           y0;
        logic [C-1:0]           x1;
        logic [C-1:0]           y1;
        logic [C-1:0]           dx;
        logic [C-1:0]           dy;
        logic                   sx_neg;
        logic                   sy_neg;
        logic                   single;
        logic [COLOR_BITS-1:0]  color;
    } t_entry;

    t_entry entry;

    // Walk state.
    logic [C-1:0]          r_cur_x, n_cur_x;
    logic [C-1:0]          r_cur_y, n_cur_y;
    logic [C-1:0]          r_tgt_x, n_tgt_x;
    logic [C-1:0]          r_tgt_y, n_tgt_y;
    logic [C-1:0]          r_dx, n_dx;
    logic [C-1:0]          r_dy, n_dy;
    logic                  r_sx_neg, n_sx_neg;
    logic                  r_sy_neg, n_sy_neg;
    logic signed [EW-1:0]  r_err, n_err;
    logic                  r_active, n_active;
    logic [COLOR_BITS-1:0] r_color, n_color;

    // Output register.
    logic                  r_o_valid, n_o_valid;
    logic [C-1:0]          r_o_x, n_o_x;
    logic [C-1:0]          r_o_y, n_o_y;
    logic [COLOR_BITS-1:0] r_o_color, n_o_color;
    logic                  r_o_pv, n_o_pv;
    logic                  r_o_last, n_o_last;

    logic signed [EW:0]    e2, dx_e, dy_e;
    logic                  move_x, move_y;
    logic [C-1:0]          step_x, step_y;

    assign entry = t_entry'(i_entry);

    // Pop a command when the output register is empty or being emptied.
    assign o_pop = i_valid && (!r_o_valid || o_pix.ready);

    // Bresenham decision on the doubled error.
    assign e2     = {r_err, 1'b0};
    assign dx_e   = $signed({{(EW+1-C){1'b0}}, r_dx});
    assign dy_e   = $signed({{(EW+1-C){1'b0}}, r_dy});
    assign move_x = (e2 > -dy_e);
    assign move_y = (e2 < dx_e);
    assign step_x = r_sx_neg ? r_cur_x - C'(1) : r_cur_x + C'(1);
    assign step_y = r_sy_neg ? r_cur_y - C'(1) : r_cur_y + C'(1);

    // Carry out the popped command.
    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_tgt_x   = r_tgt_x;
        n_tgt_y   = r_tgt_y;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_sx_neg  = r_sx_neg;
        n_sy_neg  = r_sy_neg;
        n_err     = r_err;
        n_active  = r_active;
        n_color   = r_color;
        n_o_valid = r_o_valid && !o_pix.ready;
        n_o_x     = r_o_x;
        n_o_y     = r_o_y;
        n_o_color = r_o_color;
        n_o_pv    = r_o_pv;
        n_o_last  = r_o_last;
        if (o_pop) begin
            n_o_valid = 1'b1;
            case (entry.cmd)
                CMD_START: begin
                    n_cur_x   = entry.x0;
                    n_cur_y   = entry.y0;
                    n_tgt_x   = entry.x1;
                    n_tgt_y   = entry.y1;
                    n_dx      = entry.dx;
                    n_dy      = entry.dy;
                    n_sx_neg  = entry.sx_neg;
                    n_sy_neg  = entry.sy_neg;
                    n_err     = $signed({3'b000, entry.dx}) - $signed({3'b000, entry.dy});
                    n_active  = !entry.single;
                    n_color   = entry.color;
                    n_o_x     = entry.x1;
                    n_o_y     = entry.y1;
                    n_o_color = entry.color;
                    n_o_pv    = 1'b1;
                    n_o_last  = entry.single;
                end
                CMD_STEP: begin
                    if (r_active) begin
                        n_err = r_err
                              - (move_x ? $signed({3'b000, r_dy}) : EW'(0))
                              + (move_y ? $signed({3'b000, r_dx}) : EW'(0));
                        n_cur_x   = move_x ? step_x : r_cur_x;
                        n_cur_y   = move_y ? step_y : r_cur_y;
                        n_active  = !((n_cur_x == r_tgt_x) && (n_cur_y == r_tgt_y));
                        n_o_x     = r_cur_x;
                        n_o_y     = r_cur_y;
                        n_o_color = r_color;
                        n_o_pv    = 1'b1;
                        n_o_last  = !n_active;
                    end else begin
                        n_o_x     = '0;
                        n_o_y     = '0;
                        n_o_color = '0;
                        n_o_pv    = 1'b0;
                        n_o_last  = 1'b0;
                    end
                end
                default: begin
                    n_o_valid = r_o_valid;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        r_cur_x   <= n_cur_x;
        r_cur_y   <= n_cur_y;
        r_tgt_x   <= n_tgt_x;
        r_tgt_y   <= n_tgt_y;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_sx_neg  <= n_sx_neg;
        r_sy_neg  <= n_sy_neg;
        r_err     <= n_err;
        r_color   <= n_color;
        r_o_x     <= n_o_x;
        r_o_y     <= n_o_y;
        r_o_color <= n_o_color;
        r_o_pv    <= n_o_pv;
        r_o_last  <= n_o_last;
    end

    assign o_pix.valid       = r_o_valid;
    assign o_pix.pixel_x     = r_o_x;
    assign o_pix.pixel_y     = r_o_y;
    assign o_pix.pixel_color = r_o_color;
    assign o_pix.pixel_valid = r_o_pv;
    assign o_pix.last        = r_o_last;

    a_single_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (entry.cmd == CMD_START) && entry.single |=> !r_active)
        else $error("a line with equal endpoints left the walker active");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (entry.cmd == CMD_STEP) && r_active && !n_active |=> r_o_last && r_o_pv)
        else $error("end of walk was not flagged as last");

    a_idle_step_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_pv |-> !r_o_last && (r_o_x == '0) && (r_o_color == '0))
        else $error("blank answer carries a pixel");

endmodule

`default_nettype wire

>>> hw/rtl/line_rasterizer.sv
// Line rasterizer: a Bresenham line walker for all octants.
// i_cmd carries command items. A start command (command 0) latches both
// endpoints and the color and is answered with the far endpoint; last is
// set on that answer when both endpoints are equal. Each step command
// (command 1) is answered with the next pixel of the walk from the start
// point, last marking the final one. A step with no line running is
// answered with pixel_valid low and all other fields zero.
// o_pix carries exactly one answer item for every command item.
// An accepted command passes through the queue and the walker into the output
// register. Throughput: one command per cycle while the receiver takes answers;
// each step updates and compares the error term in the walker.
// A small command queue sits between the input stage and the walker. While
// an answer waits in the output register the walker holds, so a stalled
// receiver backs up the queue and then i_cmd.ready drops.
// Reset (synchronous, active low) empties the queue and output register and
// leaves the walker idle.
`default_nettype none

module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lr_in_if.sink     i_cmd,
    lr_out_if.source  o_pix
);
    import lr_pkg::*;

    localparam int ENTRY_W = 4 + 6 * COORD_BITS + COLOR_BITS;

    logic               q_push, q_full, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_in, q_out;

    lr_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_cmd   (i_cmd),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    lr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_out),
        .o_pop   (q_pop),
        .o_pix   (o_pix)
    );

endmodule

`default_nettype wire

>>> tb/tb_line_rasterizer.sv
`timescale 1ns / 100ps

module tb_line_rasterizer;

    localparam int CB        = lr_pkg::COORD_BITS_DEF;
    localparam int CLR       = lr_pkg::COLOR_BITS;
    localparam int COORD_MIN = -(1 << (CB - 1));
    localparam int COORD_MAX = (1 << (CB - 1)) - 1;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic                  command;
        logic signed [CB-1:0]  sx;
        logic signed [CB-1:0]  sy;
        logic signed [CB-1:0]  ex;
        logic signed [CB-1:0]  ey;
        logic [CLR-1:0]        color;
    } t_line_cmd;

    typedef struct {
        logic signed [CB-1:0]  x;
        logic signed [CB-1:0]  y;
        logic [CLR-1:0]        color;
        logic                  pv;
        logic                  last;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    lr_in_if  #(.COORD_BITS(CB)) cmd_bus ();
    lr_out_if #(.COORD_BITS(CB)) pix_bus ();

    line_rasterizer #(.COORD_BITS(CB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_pix   (pix_bus)
    );

    // Commands waiting to be driven and pixels waiting to be received.
    t_line_cmd pending_cmds[$];
    t_pixel    expected_pixels[$];

    int  n_errors    = 0;
    int  n_accepted  = 0;
    int  total_items = 0;
    int  cycle_count = 0;
    bit  cmd_taken   = 1'b0;

    // Walker state of the line being drawn.
    logic signed [CB-1:0]  walk_x, walk_y, goal_x, goal_y;
    logic [CB-1:0]         span_x, span_y;
    logic                  x_back, y_back;
    logic signed [CB+1:0]  err_acc;
    logic                  walking;
    logic [CLR-1:0]        latched_color;

    // Works out the answer to one command and advances the walker.
    function automatic t_pixel next_pixel(input t_line_cmd c);
        t_pixel p;
        int dxi, dyi, e2;
        p = '{x: '0, y: '0, color: '0, pv: 1'b0, last: 1'b0};
        if (c.command == lr_pkg::CMD_START) begin
            dxi = int'(c.ex) - int'(c.sx);
            dyi = int'(c.ey) - int'(c.sy);
            latched_color = c.color;
            walk_x = c.sx;
            walk_y = c.sy;
            goal_x = c.ex;
            goal_y = c.ey;
            span_x = CB'((dxi < 0) ? -dxi : dxi);
            span_y = CB'((dyi < 0) ? -dyi : dyi);
            x_back = !(c.sx < c.ex);
            y_back = !(c.sy < c.ey);
            err_acc = (CB + 2)'(int'(span_x) - int'(span_y));
            walking = (dxi != 0) || (dyi != 0);
            p = '{x: c.ex, y: c.ey, color: c.color, pv: 1'b1, last: !walking};
        end else if (walking) begin
            p.x = walk_x;
            p.y = walk_y;
            p.color = latched_color;
            p.pv = 1'b1;
            e2 = 2 * int'(err_acc);
            if (e2 > -int'(span_y)) begin
                err_acc = (CB + 2)'(int'(err_acc) - int'(span_y));
                walk_x = x_back ? walk_x - CB'(1) : walk_x + CB'(1);
            end
            if (e2 < int'(span_x)) begin
                err_acc = (CB + 2)'(int'(err_acc) + int'(span_x));
                walk_y = y_back ? walk_y - CB'(1) : walk_y + CB'(1);
            end
            if (walk_x == goal_x && walk_y == goal_y) begin
                walking = 1'b0;
            end
            p.last = !walking;
        end
        return p;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // A step command carries random payload, which the block must ignore.
    function automatic void add_step();
        t_line_cmd c;
        c.command = lr_pkg::CMD_STEP;
        c.sx = CB'($urandom);
        c.sy = CB'($urandom);
        c.ex = CB'($urandom);
        c.ey = CB'($urandom);
        c.color = CLR'($urandom);
        pending_cmds.push_back(c);
    endfunction

    // A start command followed by a number of steps.
    function automatic void add_line(input int x0, input int y0, input int x1,
                                     input int y1, input int color, input int steps);
        t_line_cmd c;
        c.command = lr_pkg::CMD_START;
        c.sx = CB'(x0);
        c.sy = CB'(y0);
        c.ex = CB'(x1);
        c.ey = CB'(y1);
        c.color = CLR'(color);
        pending_cmds.push_back(c);
        repeat (steps) add_step();
    endfunction

    // Idle rates per phase: sender mostly busy first, then the receiver, then both always busy.
    function automatic int send_idle_pct();
        if (n_accepted < total_items / 3) return 31;
        if (n_accepted < 2 * total_items / 3) return 62;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_accepted < total_items / 3) return 62;
        if (n_accepted < 2 * total_items / 3) return 31;
        return 0;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Command driver: a new item goes out at the falling edge once the last was taken.
    always @(negedge i_clk) begin
        t_line_cmd nc;
        if (i_rst_n && (!cmd_bus.valid || cmd_taken)) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                nc = pending_cmds.pop_front();
                cmd_bus.valid   <= 1'b1;
                cmd_bus.command <= nc.command;
                cmd_bus.start_x <= nc.sx;
                cmd_bus.start_y <= nc.sy;
                cmd_bus.end_x   <= nc.ex;
                cmd_bus.end_y   <= nc.ey;
                cmd_bus.color   <= nc.color;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
        cmd_taken = 1'b0;
        pix_bus.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct());
    end

    // Accepted commands go through the predictor.
    always @(posedge i_clk) begin
        t_line_cmd c;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            c.command = cmd_bus.command;
            c.sx = cmd_bus.start_x;
            c.sy = cmd_bus.start_y;
            c.ex = cmd_bus.end_x;
            c.ey = cmd_bus.end_y;
            c.color = cmd_bus.color;
            expected_pixels.push_back(next_pixel(c));
            cmd_taken = 1'b1;
            n_accepted++;
        end
    end

    // Pixel monitor: each answer item is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (expected_pixels.size() == 0) begin
                if (n_errors < 40) begin
                    $display("%0t: unexpected pixel item x=%0d y=%0d color=%h valid=%b last=%b",
                             $time, pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color,
                             pix_bus.pixel_valid, pix_bus.last);
                end
                n_errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (pix_bus.pixel_x !== want.x || pix_bus.pixel_y !== want.y ||
                    pix_bus.pixel_color !== want.color ||
                    pix_bus.pixel_valid !== want.pv || pix_bus.last !== want.last) begin
                    if (n_errors < 40) begin
                        $display("%0t: pixel mismatch: expected x=%0d y=%0d color=%h valid=%b last=%b",
                                 $time, want.x, want.y, want.color, want.pv, want.last);
                        $display("%0t:                 actual   x=%0d y=%0d color=%h valid=%b last=%b",
                                 $time, pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color,
                                 pix_bus.pixel_valid, pix_bus.last);
                    end
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int kind, mag, dx, dy, x0, y0, x1, y1, steps;
        i_rst_n = 1'b0;
        walking = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = lr_pkg::CMD_START;
        cmd_bus.start_x = '0;
        cmd_bus.start_y = '0;
        cmd_bus.end_x = '0;
        cmd_bus.end_y = '0;
        cmd_bus.color = '0;
        pix_bus.ready = 1'b0;

        // Directed part: idle step, single point lines, corner to corner lines,
        // a line abandoned by a new start, and full walks in two directions.
        add_step();
        add_line(5, -3, 5, -3, 24'hFFFFFF, 1);
        add_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 24'h000000, 3);
        add_line(0, 0, 3, 1, 24'h123456, 3);
        add_step();
        add_line(0, 0, -1, -4, 24'hA5A5A5, 4);
        add_line(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 24'h5A5A5A, 0);
        add_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h800001, 2);

        // Random part: mostly complete short lines, some abandoned lines and loose steps.
        while (pending_cmds.size() < RANDOM_ITEMS + 21) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                mag = ($urandom_range(0, 19) == 0) ? 200 : 12;
                dx = $urandom_range(0, mag);
                dy = $urandom_range(0, mag);
                if ($urandom_range(0, 1) != 0) dx = -dx;
                if ($urandom_range(0, 1) != 0) dy = -dy;
                x0 = $urandom_range(0, 2 * COORD_MAX + 1) + COORD_MIN;
                y0 = $urandom_range(0, 2 * COORD_MAX + 1) + COORD_MIN;
                x1 = clamp_coord(x0 + dx);
                y1 = clamp_coord(y0 + dy);
                steps = (abs_int(x1 - x0) > abs_int(y1 - y0)) ? abs_int(x1 - x0)
                                                               : abs_int(y1 - y0);
                if ($urandom_range(0, 7) == 0) steps++;
                add_line(x0, y0, x1, y1, $urandom, steps);
            end else if (kind < 85) begin
                x0 = $urandom_range(0, 2 * COORD_MAX + 1) + COORD_MIN;
                y0 = $urandom_range(0, 2 * COORD_MAX + 1) + COORD_MIN;
                x1 = $urandom_range(0, 2 * COORD_MAX + 1) + COORD_MIN;
                y1 = $urandom_range(0, 2 * COORD_MAX + 1) + COORD_MIN;
                add_line(x0, y0, x1, y1, $urandom, $urandom_range(0, 6));
            end else begin
                repeat ($urandom_range(1, 3)) add_step();
            end
        end
        total_items = pending_cmds.size();

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d expected pixel items never arrived", $time,
                     expected_pixels.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_if.sv
hw/rtl/lr_fifo.sv
hw/rtl/lr_front.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer.sv
tb/tb_line_rasterizer.sv
